[hdl/pds_pkg.sv]
`default_nettype none
package pds_pkg;

    localparam int unsigned SS_VCO_MIN   = 128000;
    localparam int unsigned TS_VCO_MIN   = 400000;
    localparam int unsigned TS_VCO_MAX   = 1000000;
    localparam int unsigned TS_P_MAX     = 6;
    localparam int unsigned TS_M_MAX     = 13;
    localparam int unsigned TS_N_MIN     = 5;
    localparam int unsigned TS_N_MAX     = 255;
    localparam int unsigned SS_N_LIMIT   = 256;
    localparam logic [31:0] TS_SECOND_WORD = 32'h8000_0401;

    // register indexes
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_REF    = 3'd1;
    localparam logic [2:0] REG_MAXVCO = 3'd2;
    localparam logic [2:0] REG_PMAX   = 3'd3;
    localparam logic [2:0] REG_MMIN   = 3'd4;
    localparam logic [2:0] REG_MMAX   = 3'd5;

    localparam int unsigned NUM_W = 36;  // dividend width
    localparam int unsigned DEN_W = 18;  // divisor width

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PCHK,
        ST_NDIV_GO,
        ST_NDIV_WAIT,
        ST_NCHK,
        ST_CDIV_GO,
        ST_CDIV_WAIT,
        ST_CONSIDER,
        ST_NEXT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic init;       // load request, p/m start values
        logic p_next;     // advance P, reset M
        logic m_next;     // advance M
        logic ndiv_start; // start N division
        logic cdiv_start; // start clock division
        logic latch_n;
        logic consider;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic p_ok;
        logic p_last;
        logic m_last;
        logic m_skip;   // M zero or empty range
        logic ref_zero;
        logic n_ok;
        logic div_done;
    } t_status;

endpackage
`default_nettype wire

[hdl/pll_divider_search.sv]
// PLL divider search.
// Input channel: i_valid/o_ready carries one requested clock word (i_clock_in, kHz).
// Output channel: o_valid/i_ready carries one result word per request:
// found flag, M, N, P, achieved clock, and in two-stage mode the packed
// coefficient word and the fixed second-stage word.
// Configuration: i_cfg_we writes register i_cfg_idx with i_cfg_data
// (0 mode, 1 reference kHz, 2 max VCO, 3 P max, 4 M min, 5 M max).
// Each accepted candidate uses the shared one-bit-per-cycle divider twice,
// once for N and once for the achieved clock; one word is in flight at a time.
// A new word is taken once the search finishes and the previous result
// has left or is leaving the output register. A stalled receiver holds
// the result and blocks the input.
// Reset restores register defaults and empties the output register.
`default_nettype none
module pll_divider_search (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [19:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [19:0] i_clock_in,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_found,
    output logic [3:0]       o_m_div,
    output logic [7:0]       o_n_div,
    output logic [2:0]       o_p_div,
    output logic [24:0]      o_clock_out,
    output logic [18:0]      o_coeff_word,
    output logic [31:0]      o_second_coeff
);
    logic        r_mode;
    logic [15:0] r_ref;
    logic [19:0] r_max_vco;
    logic [2:0]  r_pmax;
    logic [3:0]  r_mmin;
    logic [3:0]  r_mmax;

    pds_pkg::t_cmd    w_cmd;
    pds_pkg::t_status w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b0;
            r_ref     <= 16'd14318;
            r_max_vco <= 20'd350000;
            r_pmax    <= 3'd4;
            r_mmin    <= 4'd8;
            r_mmax    <= 4'd14;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pds_pkg::REG_MODE:   r_mode    <= i_cfg_data[0];
                pds_pkg::REG_REF:    r_ref     <= i_cfg_data[15:0];
                pds_pkg::REG_MAXVCO: r_max_vco <= i_cfg_data;
                pds_pkg::REG_PMAX:   r_pmax    <= i_cfg_data[2:0];
                pds_pkg::REG_MMIN:   r_mmin    <= i_cfg_data[3:0];
                pds_pkg::REG_MMAX:   r_mmax    <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    pds_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    pds_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_clock_in     (i_clock_in),
        .i_mode         (r_mode),
        .i_ref          (r_ref),
        .i_max_vco      (r_max_vco),
        .i_pmax         (r_pmax),
        .i_mmin         (r_mmin),
        .i_mmax         (r_mmax),
        .o_found        (o_found),
        .o_m_div        (o_m_div),
        .o_n_div        (o_n_div),
        .o_p_div        (o_p_div),
        .o_clock_out    (o_clock_out),
        .o_coeff_word   (o_coeff_word),
        .o_second_coeff (o_second_coeff)
    );
endmodule
`default_nettype wire

[hdl/pds_divider.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module pds_divider (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic [pds_pkg::NUM_W-1:0]      i_num,
    input  wire logic [pds_pkg::DEN_W-1:0]      i_den,
    output logic                                o_done,
    output logic [pds_pkg::NUM_W-1:0]           o_quot
);
    localparam int unsigned CW = $clog2(pds_pkg::NUM_W + 1);

    logic [pds_pkg::NUM_W-1:0] r_quot, n_quot;
    logic [pds_pkg::DEN_W:0]   r_rem, n_rem;
    logic [pds_pkg::DEN_W-1:0] r_den;
    logic [CW-1:0]             r_cnt;
    logic                      r_busy;
    logic [pds_pkg::DEN_W:0]   w_trial;

    always_comb begin
        w_trial = {r_rem[pds_pkg::DEN_W-1:0], r_quot[pds_pkg::NUM_W-1]};
        n_quot  = {r_quot[pds_pkg::NUM_W-2:0], 1'b0};
        n_rem   = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem     = w_trial - {1'b0, r_den};
            n_quot[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(pds_pkg::NUM_W);
                r_quot <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_quot <= n_quot;
                r_rem  <= n_rem;
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_quot;
endmodule
`default_nettype wire

[hdl/pds_datapath.sv]
`default_nettype none
module pds_datapath (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire pds_pkg::t_cmd        i_cmd,
    output pds_pkg::t_status          o_status,
    input  wire logic [19:0]          i_clock_in,
    input  wire logic                 i_mode,
    input  wire logic [15:0]          i_ref,
    input  wire logic [19:0]          i_max_vco,
    input  wire logic [2:0]           i_pmax,
    input  wire logic [3:0]           i_mmin,
    input  wire logic [3:0]           i_mmax,
    output logic                      o_found,
    output logic [3:0]                o_m_div,
    output logic [7:0]                o_n_div,
    output logic [2:0]                o_p_div,
    output logic [24:0]               o_clock_out,
    output logic [18:0]               o_coeff_word,
    output logic [31:0]               o_second_coeff
);
    localparam int unsigned NW = pds_pkg::NUM_W;
    localparam int unsigned DW = pds_pkg::DEN_W;

    logic [19:0] r_req;
    logic [2:0]  r_p;
    logic [3:0]  r_m;
    logic [7:0]  r_n;
    logic [26:0] r_vco;
    logic        r_ok;
    logic [25:0] r_err;
    logic [3:0]  r_bm;
    logic [7:0]  r_bn;
    logic [2:0]  r_bp;
    logic [24:0] r_bclk;
    logic [NW-1:0] r_prod;

    logic [17:0] w_refx;
    logic [2:0]  w_plim;
    logic [NW-1:0] w_num;
    logic [DW-1:0] w_den;
    logic          w_done;
    logic [NW-1:0] w_quot;
    logic [NW-1:0] w_clk;
    logic [NW-1:0] w_err;

    assign w_refx = i_mode ? {i_ref, 2'b00} : {2'b00, i_ref};
    assign w_plim = i_mode ? 3'(pds_pkg::TS_P_MAX) : i_pmax;

    // registered product of either reference and N or VCO and M
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_n)
            r_prod <= NW'(w_refx * 26'(w_quot[7:0]));
        else
            r_prod <= NW'(31'(r_vco) * 31'(r_m));
    end

    always_comb begin
        if (i_cmd.cdiv_start) begin
            w_num = r_prod;
            w_den = DW'(r_m);
        end else begin
            w_num = i_mode ? r_prod : r_prod + NW'(i_ref[15:1]);
            w_den = w_refx;
        end
    end

    pds_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.ndiv_start | i_cmd.cdiv_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_done),
        .o_quot  (w_quot)
    );

    assign w_clk = w_quot >> r_p;
    assign w_err = (w_clk > NW'(r_req)) ? w_clk - NW'(r_req) : NW'(r_req) - w_clk;

    always_comb begin
        o_status.div_done = w_done;
        o_status.ref_zero = (i_ref == 16'd0);
        o_status.p_last   = (r_p == w_plim);
        o_status.m_last   = i_mode ? (r_m == 4'(pds_pkg::TS_M_MAX)) : (r_m >= i_mmax);
        o_status.m_skip   = !i_mode && ((r_m == 4'd0) || (r_m > i_mmax));
        if (i_mode)
            o_status.p_ok = (r_vco >= 27'(pds_pkg::TS_VCO_MIN) || r_p == w_plim)
                            && r_vco <= 27'(pds_pkg::TS_VCO_MAX);
        else
            o_status.p_ok = (r_vco >= 27'(pds_pkg::SS_VCO_MIN) || r_p == w_plim)
                            && r_vco <= 27'(i_max_vco);
        if (i_mode)
            o_status.n_ok = w_quot >= NW'(pds_pkg::TS_N_MIN)
                            && w_quot <= NW'(pds_pkg::TS_N_MAX);
        else
            o_status.n_ok = w_quot < NW'(pds_pkg::SS_N_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_req <= i_clock_in;
            r_p   <= 3'd0;
            r_vco <= 27'(i_clock_in);
            r_m   <= i_mode ? 4'd1 : i_mmin;
            r_ok  <= 1'b0;
        end
        if (i_cmd.p_next) begin
            r_p   <= r_p + 3'd1;
            r_vco <= 27'(r_req) << (r_p + 3'd1);
            r_m   <= i_mode ? 4'd1 : i_mmin;
        end
        if (i_cmd.m_next)
            r_m <= r_m + 4'd1;
        if (i_cmd.latch_n)
            r_n <= w_quot[7:0];
        if (i_cmd.consider && (!r_ok || 26'(w_err) < r_err)) begin
            r_ok   <= 1'b1;
            r_err  <= 26'(w_err);
            r_bm   <= r_m;
            r_bn   <= r_n;
            r_bp   <= r_p;
            r_bclk <= 25'(w_clk);
        end
        if (i_cmd.finish) begin
            o_found        <= r_ok;
            o_m_div        <= r_ok ? r_bm : 4'd0;
            o_n_div        <= r_ok ? r_bn : 8'd0;
            o_p_div        <= r_ok ? r_bp : 3'd0;
            o_clock_out    <= r_ok ? r_bclk : 25'd0;
            o_coeff_word   <= (r_ok && i_mode) ? {r_bp, r_bn, 4'd0, r_bm} : 19'd0;
            o_second_coeff <= (r_ok && i_mode) ? pds_pkg::TS_SECOND_WORD : 32'd0;
        end
    end
endmodule
`default_nettype wire

[hdl/pds_ctrl.sv]
`default_nettype none
module pds_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    output logic                  o_valid,
    input  wire logic             i_ready,
    input  wire pds_pkg::t_status i_status,
    output pds_pkg::t_cmd         o_cmd
);
    pds_pkg::t_state r_state, n_state;
    logic r_valid, n_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pds_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_ready = (r_state == pds_pkg::ST_IDLE) && (!r_valid || i_ready);

    always_comb begin
        n_state = r_state;
        n_valid = r_valid && !i_ready;
        o_cmd   = '0;
        case (r_state)
            pds_pkg::ST_IDLE: begin
                if (i_valid && o_ready) begin
                    o_cmd.init = 1'b1;
                    n_state    = pds_pkg::ST_PCHK;
                end
            end
            pds_pkg::ST_PCHK: begin
                if (i_status.ref_zero)
                    n_state = pds_pkg::ST_DONE;
                else if (i_status.p_ok)
                    n_state = pds_pkg::ST_NDIV_GO;
                else
                    n_state = pds_pkg::ST_NEXT;
            end
            pds_pkg::ST_NDIV_GO: begin
                // product of vco and M is registered now
                if (i_status.m_skip)
                    n_state = pds_pkg::ST_NEXT;
                else begin
                    o_cmd.ndiv_start = 1'b1;
                    n_state = pds_pkg::ST_NDIV_WAIT;
                end
            end
            pds_pkg::ST_NDIV_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.latch_n = 1'b1;
                    n_state = i_status.n_ok ? pds_pkg::ST_CDIV_GO : pds_pkg::ST_NEXT;
                end
            end
            pds_pkg::ST_CDIV_GO: begin
                o_cmd.cdiv_start = 1'b1;
                n_state = pds_pkg::ST_CDIV_WAIT;
            end
            pds_pkg::ST_CDIV_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.consider = 1'b1;
                    n_state = pds_pkg::ST_NEXT;
                end
            end
            pds_pkg::ST_NEXT: begin
                // a zero M is skipped but the range goes on; past the top ends it
                if (i_status.p_ok && !i_status.m_last) begin
                    o_cmd.m_next = 1'b1;
                    n_state = pds_pkg::ST_CONSIDER;
                end else if (i_status.p_last)
                    n_state = pds_pkg::ST_DONE;
                else begin
                    o_cmd.p_next = 1'b1;
                    n_state = pds_pkg::ST_PCHK;
                end
            end
            pds_pkg::ST_CONSIDER: begin
                // lets the product register pick up the new M
                n_state = pds_pkg::ST_NDIV_GO;
            end
            pds_pkg::ST_DONE: begin
                o_cmd.finish = 1'b1;
                n_valid = 1'b1;
                n_state = pds_pkg::ST_IDLE;
            end
            default: n_state = pds_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb;

    typedef struct {
        logic        found;
        logic [3:0]  m_div;
        logic [7:0]  n_div;
        logic [2:0]  p_div;
        logic [24:0] clock_out;
        logic [18:0] coeff_word;
        logic [31:0] second_coeff;
    } t_setting;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [19:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [19:0] i_clock_in;
    logic        o_valid;
    logic        i_ready;
    logic        o_found;
    logic [3:0]  o_m_div;
    logic [7:0]  o_n_div;
    logic [2:0]  o_p_div;
    logic [24:0] o_clock_out;
    logic [18:0] o_coeff_word;
    logic [31:0] o_second_coeff;

    pll_divider_search i_dut (.*);

    // shadow of the configuration registers
    logic        cfg_two_stage;
    logic [15:0] cfg_ref;
    logic [19:0] cfg_max_vco;
    logic [2:0]  cfg_p_max;
    logic [3:0]  cfg_m_min;
    logic [3:0]  cfg_m_max;

    logic [19:0] pending_clocks[$];
    t_setting    expected_settings[$];
    int          errors = 0;
    longint      cycle = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_phase = 0;

    function automatic t_setting best_setting(logic [19:0] req);
        t_setting     r;
        longint unsigned rf, vco, n, clk, e, best_err;
        int           p_top, m_lo, m_hi;
        bit           hit;
        r = '{default: '0};
        hit = 0;
        best_err = 0;
        if (cfg_two_stage) begin
            rf = longint'(cfg_ref) << 2;
            p_top = int'(pds_pkg::TS_P_MAX); m_lo = 1; m_hi = int'(pds_pkg::TS_M_MAX);
        end else begin
            rf = cfg_ref;
            p_top = int'(cfg_p_max); m_lo = int'(cfg_m_min); m_hi = int'(cfg_m_max);
        end
        if (rf != 0) begin
            for (int p = 0; p <= p_top; p++) begin
                vco = longint'(req) << p;
                if (cfg_two_stage) begin
                    if (!((vco >= pds_pkg::TS_VCO_MIN || p == p_top)
                          && vco <= pds_pkg::TS_VCO_MAX))
                        continue;
                end else begin
                    if (!((vco >= pds_pkg::SS_VCO_MIN || p == p_top) && vco <= cfg_max_vco))
                        continue;
                end
                for (int m = m_lo; m <= m_hi; m++) begin
                    if (m == 0) continue;
                    if (cfg_two_stage) begin
                        n = (vco * m) / rf;
                        if (n < pds_pkg::TS_N_MIN || n > pds_pkg::TS_N_MAX) continue;
                    end else begin
                        n = (vco * m + rf / 2) / rf;
                        if (n >= pds_pkg::SS_N_LIMIT) continue;
                    end
                    clk = ((rf * n) / m) >> p;
                    e = (clk > req) ? clk - req : req - clk;
                    if (!hit || e < best_err) begin
                        hit = 1;
                        best_err = e;
                        r.found = 1;
                        r.m_div = 4'(m);
                        r.n_div = 8'(n);
                        r.p_div = 3'(p);
                        r.clock_out = 25'(clk);
                    end
                end
            end
        end
        if (hit && cfg_two_stage) begin
            r.coeff_word = {r.p_div, r.n_div, 4'd0, r.m_div};
            r.second_coeff = pds_pkg::TS_SECOND_WORD;
        end
        return r;
    endfunction

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // driver: bursts with random gaps
    always @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            expected_settings.push_back(best_setting(i_clock_in));
        end
        if (!i_valid || o_ready) begin
            if (i_valid && o_ready) void'(pending_clocks.pop_front());
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 0;
            end else if (pending_clocks.size() > 0 && i_rst_n) begin
                i_valid <= 1;
                i_clock_in <= pending_clocks[0];
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 6);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 0;
            end
        end
    end

    // monitor: receiver stalls on a rotating pattern
    always @(posedge i_clk) begin
        t_setting want;
        cycle <= cycle + 1;
        stall_phase <= (stall_phase + 1) % 97;
        i_ready <= (stall_phase < 30) ? 1'b1 : ($urandom_range(0, 3) != 0);
        if (o_valid && i_ready) begin
            if (expected_settings.size() == 0) begin
                $display("%0t unexpected word: expected none, actual clock %0d", $realtime,
                         o_clock_out);
                errors++;
            end else begin
                want = expected_settings.pop_front();
                if ({o_found, o_m_div, o_n_div, o_p_div, o_clock_out, o_coeff_word,
                     o_second_coeff} !== {want.found, want.m_div, want.n_div, want.p_div,
                     want.clock_out, want.coeff_word, want.second_coeff}) begin
                    $display("%0t mismatch: expected f=%0d m=%0d n=%0d p=%0d clk=%0d cw=%h sc=%h",
                             $realtime, want.found, want.m_div, want.n_div, want.p_div,
                             want.clock_out, want.coeff_word, want.second_coeff);
                    $display("%0t           actual f=%0d m=%0d n=%0d p=%0d clk=%0d cw=%h sc=%h",
                             $realtime, o_found, o_m_div, o_n_div, o_p_div, o_clock_out,
                             o_coeff_word, o_second_coeff);
                    errors++;
                end
            end
        end
        if (cycle > 3000000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [19:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            pds_pkg::REG_MODE:   cfg_two_stage = val[0];
            pds_pkg::REG_REF:    cfg_ref = val[15:0];
            pds_pkg::REG_MAXVCO: cfg_max_vco = val;
            pds_pkg::REG_PMAX:   cfg_p_max = val[2:0];
            pds_pkg::REG_MMIN:   cfg_m_min = val[3:0];
            pds_pkg::REG_MMAX:   cfg_m_max = val[3:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic drain;
        while (pending_clocks.size() > 0 || i_valid || expected_settings.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_all(logic mode, logic [15:0] rf, logic [19:0] vco, logic [2:0] pm,
                           logic [3:0] mlo, logic [3:0] mhi);
        write_reg(pds_pkg::REG_MODE, 20'(mode));
        write_reg(pds_pkg::REG_REF, 20'(rf));
        write_reg(pds_pkg::REG_MAXVCO, vco);
        write_reg(pds_pkg::REG_PMAX, 20'(pm));
        write_reg(pds_pkg::REG_MMIN, 20'(mlo));
        write_reg(pds_pkg::REG_MMAX, 20'(mhi));
    endtask

    // mostly realistic pixel clocks, some small values and full-range noise
    function automatic logic [19:0] pick_clock();
        case ($urandom_range(0, 5))
            0:       return 20'($urandom);
            1:       return 20'($urandom_range(0, 4000));
            default: return 20'($urandom_range(10000, 400000));
        endcase
    endfunction

    initial begin
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = pds_pkg::REG_MODE;
        i_cfg_data = 0;
        i_valid = 0;
        i_clock_in = 0;
        i_ready = 0;
        cfg_two_stage = 0;
        cfg_ref = 14318;
        cfg_max_vco = 350000;
        cfg_p_max = 4;
        cfg_m_min = 8;
        cfg_m_max = 14;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reset settings, field extremes
        pending_clocks = '{20'd0, 20'd1, 20'hFFFFF, 20'd25175, 20'd128000, 20'd350000,
                           20'd350001, 20'd65000, 20'haaaaa, 20'h55555};
        drain();
        set_all(1'b1, 16'd14318, 20'd350000, 3'd4, 4'd8, 4'd14);
        pending_clocks = '{20'd0, 20'd6250, 20'd25175, 20'd400000, 20'd1000000,
                           20'd1000001, 20'hFFFFF};
        drain();
        // zero reference in both modes
        write_reg(pds_pkg::REG_REF, 20'd0);
        pending_clocks = '{20'd100000};
        drain();
        write_reg(pds_pkg::REG_MODE, 20'd0);
        pending_clocks = '{20'd100000};
        drain();
        // zero divider allowed, then empty range
        set_all(1'b0, 16'hFFFF, 20'hFFFFF, 3'd7, 4'd0, 4'd15);
        pending_clocks = '{20'd1, 20'd200000, 20'hFFFFF};
        drain();
        set_all(1'b0, 16'd1, 20'd0, 3'd0, 4'd15, 4'd1);
        pending_clocks = '{20'd0, 20'd50000};
        drain();

        // random phases over random or reset settings
        for (int ph = 0; ph < 8; ph++) begin
            if (ph % 3 == 0)
                set_all(1'b0, 16'd14318, 20'd350000, 3'd4, 4'd8, 4'd14);
            else
                set_all(ph % 3 == 2, 16'($urandom_range(1, 65535)), 20'($urandom),
                        3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
                        4'($urandom_range(0, 15)));
            if (ph == 5) set_all(1'b1, 16'd65535, 20'hFFFFF, 3'd7, 4'd1, 4'd15);
            for (int k = 0; k < 16; k++) pending_clocks.push_back(pick_clock());
            drain();
        end

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
